### rtl/sae_pkg.sv
// Shared types and constants for the suffix automaton engine.
package sae_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int ALPHABET = 26;
    localparam int SW       = 13;
    localparam int NSTATE   = 1 << SW;
    localparam int SYM_W    = 5;
    localparam int TRANS_AW = SW + SYM_W;
    localparam logic [SW-1:0] ROOT = SW'(1);

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_MATCH   = 3'd3,
        CMD_COUNT   = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef enum logic [5:0] {
        OP_NONE, OP_ACCEPT, OP_DECODE, OP_INIT, OP_RESTART, OP_FULL,
        OP_AP_NEW, OP_RD_P, OP_AP_CHK, OP_AP_ROOT, OP_RD_Q, OP_AP_CMPQ,
        OP_CP_RD, OP_CP_WR, OP_LINK_CUR, OP_LINK_Q, OP_AP_RED, OP_AP_FIN,
        OP_M_START, OP_M_CHK, OP_M_ROOT, OP_M_FIN, OP_M_OUT,
        OP_C_CLR, OP_H_RL, OP_H_RB, OP_H_WB, OP_P_RD, OP_P_WR,
        OP_O_RL, OP_O_RB, OP_O_WR, OP_A_RO, OP_A_RS, OP_A_RL, OP_A_WR,
        OP_C_FIN, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic p_zero;
        logic edge_zero;
        logic edge_eq_q;
        logic len_match;
        logic cp_last;
        logic sym_ok;
        logic full;
        logic i_eq_max;
        logic i_eq_total;
        logic i_eq_one;
        logic out_busy;
    } dp_stat_t;

endpackage

### rtl/sae_datapath.sv
// Datapath of the suffix automaton engine: automaton memories, walk registers and result register.
module sae_datapath import sae_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [SYM_W-1:0]  s_symbol,
    output dp_stat_t          stat,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [12:0]       m_match_len,
    output logic [12:0]       m_best_len,
    output logic [12:0]       m_occurrences,
    output logic [1:0]        m_status
);

    // Memories.
    logic [SW-1:0]       trans_mem  [0:(1 << TRANS_AW)-1];
    logic [ALPHABET-1:0] mask_mem   [0:NSTATE-1];
    logic [SW-1:0]       link_mem   [0:NSTATE-1];
    logic [SW-1:0]       len_mem    [0:NSTATE-1];
    logic                flag_mem   [0:NSTATE-1];
    logic [SW-1:0]       cnt_mem    [0:NSTATE-1];
    logic [SW-1:0]       order_mem  [0:NSTATE-1];
    logic [SW-1:0]       bucket_mem [0:MAX_TEXT];

    logic [SW-1:0]       trans_rd, link_rd, len_rd, cnt_rd, order_rd, bucket_rd;
    logic [ALPHABET-1:0] mask_rd;
    logic                flag_rd;

    // Working registers.
    logic [SYM_W-1:0] sym_reg;
    logic [SW-1:0] p_reg, cur_reg, q_reg, cl_reg, total_reg, last_reg, tlen_reg;
    logic [SW-1:0] mst_reg, mlen_reg, best_reg, lenp_reg, lenx_reg, i_reg;
    logic [SW-1:0] acc_reg, lnk_reg, cs_reg;
    logic [SW-1:0] res_mlen_reg, res_occ_reg;
    logic [1:0]    res_st_reg;
    logic          cv_reg, first_reg;
    logic          m_valid_reg;
    logic [12:0]   m_match_len_reg, m_best_len_reg, m_occ_reg;
    logic [1:0]    m_status_reg;

    logic [ALPHABET-1:0] sym_bit;
    logic                sym_ok, edge_hit;
    logic [SW-1:0]       edge_val, new_state;

    // Port controls.
    logic                  trans_we, mask_we, link_we, len_we, flag_we, cnt_we;
    logic                  order_we, bucket_we;
    logic                  trans_re, mask_re, link_re, len_re, flag_re, cnt_re;
    logic                  order_re, bucket_re;
    logic [TRANS_AW-1:0]   trans_wa, trans_ra;
    logic [SW-1:0]         mask_wa, mask_ra, link_wa, link_ra, len_wa, len_ra;
    logic [SW-1:0]         flag_wa, cnt_wa, cnt_ra, order_wa, bucket_wa, bucket_ra;
    logic [SW-1:0]         trans_wd, link_wd, len_wd, cnt_wd, bucket_wd;
    logic [ALPHABET-1:0]   mask_wd;
    logic                  flag_wd;

    assign sym_ok    = sym_reg < SYM_W'(ALPHABET);
    assign sym_bit   = sym_ok ? (ALPHABET'(1) << sym_reg) : '0;
    assign edge_hit  = |(mask_rd & sym_bit);
    assign edge_val  = edge_hit ? trans_rd : '0;
    assign new_state = total_reg + SW'(1);

    assign stat.p_zero     = (p_reg == '0);
    assign stat.edge_zero  = !edge_hit;
    assign stat.edge_eq_q  = edge_hit && (trans_rd == q_reg);
    assign stat.len_match  = (len_rd == lenp_reg + SW'(1));
    assign stat.cp_last    = (i_reg == SW'(ALPHABET - 1));
    assign stat.sym_ok     = sym_ok;
    assign stat.full       = (tlen_reg >= SW'(MAX_TEXT));
    assign stat.i_eq_max   = (i_reg == SW'(MAX_TEXT));
    assign stat.i_eq_total = (i_reg == total_reg);
    assign stat.i_eq_one   = (i_reg == SW'(1));
    assign stat.out_busy   = m_valid_reg && !m_ready;

    always_comb begin
        trans_we = 1'b0; mask_we = 1'b0; link_we = 1'b0; len_we = 1'b0;
        flag_we = 1'b0; cnt_we = 1'b0; order_we = 1'b0; bucket_we = 1'b0;
        trans_wa = {p_reg, sym_reg}; trans_wd = cur_reg;
        mask_wa = new_state; mask_wd = '0;
        link_wa = new_state; link_wd = '0;
        len_wa = new_state; len_wd = '0;
        flag_wa = new_state; flag_wd = 1'b0;
        cnt_wa = i_reg; cnt_wd = {{(SW-1){1'b0}}, flag_rd};
        order_wa = bucket_rd; bucket_wa = i_reg; bucket_wd = '0;

        trans_re = 1'b0; mask_re = 1'b0; link_re = 1'b0; len_re = 1'b0;
        flag_re = 1'b0; cnt_re = 1'b0; order_re = 1'b0; bucket_re = 1'b0;
        trans_ra = {p_reg, sym_reg};
        mask_ra = p_reg; link_ra = p_reg; len_ra = p_reg;
        cnt_ra = order_rd; bucket_ra = i_reg;

        case (cmd.op)
            OP_INIT: begin
                mask_we = 1'b1; mask_wa = ROOT;
                link_we = 1'b1; link_wa = ROOT;
                len_we = 1'b1; len_wa = ROOT;
                flag_we = 1'b1; flag_wa = ROOT;
            end
            OP_AP_NEW: begin
                mask_we = 1'b1;
                link_we = 1'b1;
                len_we = 1'b1; len_wd = tlen_reg + SW'(1);
                flag_we = 1'b1; flag_wd = 1'b1;
            end
            OP_RD_P: begin
                trans_re = 1'b1; mask_re = 1'b1; link_re = 1'b1; len_re = 1'b1;
            end
            OP_AP_CHK: begin
                if (!edge_hit) begin
                    trans_we = 1'b1;
                    mask_we = 1'b1; mask_wa = p_reg; mask_wd = mask_rd | sym_bit;
                end
            end
            OP_AP_ROOT: begin
                link_we = 1'b1; link_wa = cur_reg; link_wd = ROOT;
            end
            OP_RD_Q: begin
                mask_re = 1'b1; mask_ra = q_reg;
                link_re = 1'b1; link_ra = q_reg;
                len_re = 1'b1; len_ra = q_reg;
            end
            OP_AP_CMPQ: begin
                link_we = 1'b1;
                if (len_rd == lenp_reg + SW'(1)) begin
                    link_wa = cur_reg; link_wd = q_reg;
                end else begin
                    // The clone takes the outgoing edges and link of q.
                    link_wd = link_rd;
                    mask_we = 1'b1; mask_wd = mask_rd;
                    len_we = 1'b1; len_wd = lenp_reg + SW'(1);
                    flag_we = 1'b1;
                end
            end
            OP_CP_RD: begin
                trans_re = 1'b1; trans_ra = {q_reg, i_reg[SYM_W-1:0]};
            end
            OP_CP_WR: begin
                trans_we = 1'b1; trans_wa = {cl_reg, i_reg[SYM_W-1:0]}; trans_wd = trans_rd;
            end
            OP_LINK_CUR: begin
                link_we = 1'b1; link_wa = cur_reg; link_wd = cl_reg;
            end
            OP_LINK_Q: begin
                link_we = 1'b1; link_wa = q_reg; link_wd = cl_reg;
            end
            OP_AP_RED: begin
                if (edge_hit && trans_rd == q_reg) begin
                    trans_we = 1'b1; trans_wd = cl_reg;
                end
            end
            OP_M_FIN: begin
                cnt_re = 1'b1; cnt_ra = mst_reg;
            end
            OP_C_CLR: begin
                bucket_we = 1'b1;
            end
            OP_H_RL: begin
                len_re = 1'b1; len_ra = i_reg;
            end
            OP_H_RB: begin
                bucket_re = 1'b1; bucket_ra = len_rd;
            end
            OP_H_WB: begin
                bucket_we = 1'b1; bucket_wa = lenx_reg; bucket_wd = bucket_rd + SW'(1);
            end
            OP_P_RD: begin
                bucket_re = 1'b1;
            end
            OP_P_WR: begin
                bucket_we = 1'b1; bucket_wd = bucket_rd + acc_reg;
            end
            OP_O_RL: begin
                len_re = 1'b1; len_ra = i_reg;
                flag_re = 1'b1;
            end
            OP_O_RB: begin
                bucket_re = 1'b1; bucket_ra = len_rd;
                cnt_we = 1'b1;
            end
            OP_O_WR: begin
                order_we = 1'b1;
                bucket_we = 1'b1; bucket_wa = lenx_reg; bucket_wd = bucket_rd - SW'(1);
            end
            OP_A_RO: begin
                order_re = 1'b1;
            end
            OP_A_RS: begin
                link_re = 1'b1; link_ra = order_rd;
                cnt_re = 1'b1; cnt_ra = order_rd;
            end
            OP_A_RL: begin
                cnt_re = 1'b1; cnt_ra = link_rd;
            end
            OP_A_WR: begin
                cnt_we = (lnk_reg != '0); cnt_wa = lnk_reg; cnt_wd = cnt_rd + cs_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (trans_we) trans_mem[trans_wa] <= trans_wd;
        if (trans_re) trans_rd <= trans_mem[trans_ra];
    end

    always_ff @(posedge aclk) begin
        if (mask_we) mask_mem[mask_wa] <= mask_wd;
        if (mask_re) mask_rd <= mask_mem[mask_ra];
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        if (link_re) link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge aclk) begin
        if (len_we) len_mem[len_wa] <= len_wd;
        if (len_re) len_rd <= len_mem[len_ra];
    end

    always_ff @(posedge aclk) begin
        if (flag_we) flag_mem[flag_wa] <= flag_wd;
        if (flag_re) flag_rd <= flag_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge aclk) begin
        if (order_we) order_mem[order_wa] <= i_reg;
        if (order_re) order_rd <= order_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (bucket_we) bucket_mem[bucket_wa] <= bucket_wd;
        if (bucket_re) bucket_rd <= bucket_mem[bucket_ra];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                sym_reg <= s_symbol;
                res_mlen_reg <= '0;
                res_occ_reg <= '0;
                res_st_reg <= ST_OK;
            end
            OP_DECODE: begin
                i_reg <= '0;
                acc_reg <= '0;
            end
            OP_INIT: begin
                total_reg <= ROOT;
                last_reg <= ROOT;
                tlen_reg <= '0;
                mst_reg <= ROOT;
                mlen_reg <= '0;
                best_reg <= '0;
                cv_reg <= 1'b0;
            end
            OP_RESTART: begin
                mst_reg <= ROOT;
                mlen_reg <= '0;
                best_reg <= '0;
            end
            OP_FULL: res_st_reg <= ST_FULL;
            OP_AP_NEW: begin
                cur_reg <= new_state;
                total_reg <= new_state;
                p_reg <= last_reg;
                last_reg <= new_state;
                tlen_reg <= tlen_reg + SW'(1);
            end
            OP_AP_CHK: begin
                if (!edge_hit) begin
                    p_reg <= link_rd;
                end else begin
                    q_reg <= edge_val;
                    lenp_reg <= len_rd;
                end
            end
            OP_AP_CMPQ: begin
                if (len_rd != lenp_reg + SW'(1)) begin
                    cl_reg <= new_state;
                    total_reg <= new_state;
                    i_reg <= '0;
                end
            end
            OP_CP_WR: i_reg <= i_reg + SW'(1);
            OP_AP_RED: begin
                if (edge_hit && trans_rd == q_reg) p_reg <= link_rd;
            end
            OP_AP_FIN: begin
                mst_reg <= ROOT;
                mlen_reg <= '0;
                cv_reg <= 1'b0;
            end
            OP_M_START: begin
                p_reg <= mst_reg;
                first_reg <= 1'b1;
            end
            OP_M_CHK: begin
                if (edge_hit) begin
                    mlen_reg <= first_reg ? (mlen_reg + SW'(1)) : (len_rd + SW'(1));
                    mst_reg <= edge_val;
                end else begin
                    p_reg <= link_rd;
                    first_reg <= 1'b0;
                end
            end
            OP_M_ROOT: begin
                mlen_reg <= '0;
                mst_reg <= ROOT;
            end
            OP_M_FIN: begin
                if (mlen_reg > best_reg) best_reg <= mlen_reg;
            end
            OP_M_OUT: begin
                res_mlen_reg <= mlen_reg;
                res_st_reg <= cv_reg ? ST_OK : ST_STALE;
                res_occ_reg <= (cv_reg && mlen_reg != '0) ? cnt_rd : '0;
            end
            OP_C_CLR: i_reg <= (i_reg == SW'(MAX_TEXT)) ? SW'(1) : i_reg + SW'(1);
            OP_H_RB: lenx_reg <= len_rd;
            OP_H_WB: i_reg <= (i_reg == total_reg) ? '0 : i_reg + SW'(1);
            OP_P_WR: begin
                acc_reg <= bucket_rd + acc_reg;
                i_reg <= (i_reg == SW'(MAX_TEXT)) ? SW'(1) : i_reg + SW'(1);
            end
            OP_O_RB: lenx_reg <= len_rd;
            OP_O_WR: begin
                if (i_reg != total_reg) i_reg <= i_reg + SW'(1);
            end
            OP_A_RL: begin
                lnk_reg <= link_rd;
                cs_reg <= cnt_rd;
            end
            OP_A_WR: i_reg <= i_reg - SW'(1);
            OP_C_FIN: cv_reg <= 1'b1;
            OP_OUT: begin
                m_match_len_reg <= res_mlen_reg;
                m_best_len_reg <= best_reg;
                m_occ_reg <= res_occ_reg;
                m_status_reg <= res_st_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_len   = m_match_len_reg;
    assign m_best_len    = m_best_len_reg;
    assign m_occurrences = m_occ_reg;
    assign m_status      = m_status_reg;

endmodule

### rtl/sae_controller.sv
// Sequencing state machine of the suffix automaton engine.
module sae_controller import sae_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [2:0] s_cmd,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd
);

    typedef enum logic [39:0] {
        S_IDLE     = 40'd1 << 0,  S_DECODE  = 40'd1 << 1,  S_INIT_RST = 40'd1 << 2,
        S_INIT_CLR = 40'd1 << 3,  S_RESTART = 40'd1 << 4,  S_FULL     = 40'd1 << 5,
        S_AP_NEW   = 40'd1 << 6,  S_AP_RD   = 40'd1 << 7,  S_AP_CHK   = 40'd1 << 8,
        S_AP_ROOT  = 40'd1 << 9,  S_AP_RDQ  = 40'd1 << 10, S_AP_CMPQ  = 40'd1 << 11,
        S_AP_CPRD  = 40'd1 << 12, S_AP_CPWR = 40'd1 << 13, S_AP_LCUR  = 40'd1 << 14,
        S_AP_LQ    = 40'd1 << 15, S_AP_RRD  = 40'd1 << 16, S_AP_RED   = 40'd1 << 17,
        S_AP_FIN   = 40'd1 << 18, S_M_START = 40'd1 << 19, S_M_RD     = 40'd1 << 20,
        S_M_CHK    = 40'd1 << 21, S_M_ROOT  = 40'd1 << 22, S_M_FIN    = 40'd1 << 23,
        S_M_OUT    = 40'd1 << 24, S_C_CLR   = 40'd1 << 25, S_C_HRL    = 40'd1 << 26,
        S_C_HRB    = 40'd1 << 27, S_C_HWB   = 40'd1 << 28, S_C_PRD    = 40'd1 << 29,
        S_C_PWR    = 40'd1 << 30, S_C_ORL   = 40'd1 << 31, S_C_ORB    = 40'd1 << 32,
        S_C_OWR    = 40'd1 << 33, S_C_ARO   = 40'd1 << 34, S_C_ARS    = 40'd1 << 35,
        S_C_ARL    = 40'd1 << 36, S_C_AWR   = 40'd1 << 37, S_C_FIN    = 40'd1 << 38,
        S_OUT      = 40'd1 << 39
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                    cmd_next = s_cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.op = OP_DECODE;
                case (cmd_reg)
                    CMD_CLEAR:   state_next = S_INIT_CLR;
                    CMD_APPEND: begin
                        if (!stat.sym_ok) state_next = S_OUT;
                        else if (stat.full) state_next = S_FULL;
                        else state_next = S_AP_NEW;
                    end
                    CMD_RESTART: state_next = S_RESTART;
                    CMD_MATCH:   state_next = S_M_START;
                    CMD_COUNT:   state_next = S_C_CLR;
                    default:     state_next = S_OUT;
                endcase
            end
            S_INIT_RST: begin
                cmd.op = OP_INIT;
                state_next = S_IDLE;
            end
            S_INIT_CLR: begin
                cmd.op = OP_INIT;
                state_next = S_OUT;
            end
            S_RESTART: begin
                cmd.op = OP_RESTART;
                state_next = S_OUT;
            end
            S_FULL: begin
                cmd.op = OP_FULL;
                state_next = S_OUT;
            end
            S_AP_NEW: begin
                cmd.op = OP_AP_NEW;
                state_next = S_AP_RD;
            end
            S_AP_RD: begin
                cmd.op = OP_RD_P;
                state_next = stat.p_zero ? S_AP_ROOT : S_AP_CHK;
            end
            S_AP_CHK: begin
                cmd.op = OP_AP_CHK;
                state_next = stat.edge_zero ? S_AP_RD : S_AP_RDQ;
            end
            S_AP_ROOT: begin
                cmd.op = OP_AP_ROOT;
                state_next = S_AP_FIN;
            end
            S_AP_RDQ: begin
                cmd.op = OP_RD_Q;
                state_next = S_AP_CMPQ;
            end
            S_AP_CMPQ: begin
                cmd.op = OP_AP_CMPQ;
                state_next = stat.len_match ? S_AP_FIN : S_AP_CPRD;
            end
            S_AP_CPRD: begin
                cmd.op = OP_CP_RD;
                state_next = S_AP_CPWR;
            end
            S_AP_CPWR: begin
                cmd.op = OP_CP_WR;
                state_next = stat.cp_last ? S_AP_LCUR : S_AP_CPRD;
            end
            S_AP_LCUR: begin
                cmd.op = OP_LINK_CUR;
                state_next = S_AP_LQ;
            end
            S_AP_LQ: begin
                cmd.op = OP_LINK_Q;
                state_next = S_AP_RRD;
            end
            S_AP_RRD: begin
                cmd.op = OP_RD_P;
                state_next = stat.p_zero ? S_AP_FIN : S_AP_RED;
            end
            S_AP_RED: begin
                cmd.op = OP_AP_RED;
                state_next = stat.edge_eq_q ? S_AP_RRD : S_AP_FIN;
            end
            S_AP_FIN: begin
                cmd.op = OP_AP_FIN;
                state_next = S_OUT;
            end
            S_M_START: begin
                cmd.op = OP_M_START;
                state_next = S_M_RD;
            end
            S_M_RD: begin
                cmd.op = OP_RD_P;
                state_next = stat.p_zero ? S_M_ROOT : S_M_CHK;
            end
            S_M_CHK: begin
                cmd.op = OP_M_CHK;
                state_next = stat.edge_zero ? S_M_RD : S_M_FIN;
            end
            S_M_ROOT: begin
                cmd.op = OP_M_ROOT;
                state_next = S_M_FIN;
            end
            S_M_FIN: begin
                cmd.op = OP_M_FIN;
                state_next = S_M_OUT;
            end
            S_M_OUT: begin
                cmd.op = OP_M_OUT;
                state_next = S_OUT;
            end
            S_C_CLR: begin
                cmd.op = OP_C_CLR;
                if (stat.i_eq_max) state_next = S_C_HRL;
            end
            S_C_HRL: begin
                cmd.op = OP_H_RL;
                state_next = S_C_HRB;
            end
            S_C_HRB: begin
                cmd.op = OP_H_RB;
                state_next = S_C_HWB;
            end
            S_C_HWB: begin
                cmd.op = OP_H_WB;
                state_next = stat.i_eq_total ? S_C_PRD : S_C_HRL;
            end
            S_C_PRD: begin
                cmd.op = OP_P_RD;
                state_next = S_C_PWR;
            end
            S_C_PWR: begin
                cmd.op = OP_P_WR;
                state_next = stat.i_eq_max ? S_C_ORL : S_C_PRD;
            end
            S_C_ORL: begin
                cmd.op = OP_O_RL;
                state_next = S_C_ORB;
            end
            S_C_ORB: begin
                cmd.op = OP_O_RB;
                state_next = S_C_OWR;
            end
            S_C_OWR: begin
                cmd.op = OP_O_WR;
                state_next = stat.i_eq_total ? S_C_ARO : S_C_ORL;
            end
            S_C_ARO: begin
                cmd.op = OP_A_RO;
                state_next = S_C_ARS;
            end
            S_C_ARS: begin
                cmd.op = OP_A_RS;
                state_next = S_C_ARL;
            end
            S_C_ARL: begin
                cmd.op = OP_A_RL;
                state_next = S_C_AWR;
            end
            S_C_AWR: begin
                cmd.op = OP_A_WR;
                state_next = stat.i_eq_one ? S_C_FIN : S_C_ARO;
            end
            S_C_FIN: begin
                cmd.op = OP_C_FIN;
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold the finished transaction until the result register is free.
                if (!stat.out_busy) begin
                    cmd.op = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT_RST;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT_RST;
            cmd_reg <= CMD_CLEAR;
        end else begin
            state_reg <= state_next;
            cmd_reg <= cmd_next;
        end
    end

endmodule

### rtl/suffix_automaton_engine_unit.sv
// Match and append walk the suffix links step by step; an append that clones a state
// also copies the whole edge row, one entry per alphabet symbol, into the clone.
// A count pass clears the bucket memory, sorts the states by length through it and sums
// the occurrence counts along the suffix links.
// One transaction is in work at a time; the result register lets the next one be accepted.
// Reset is synchronous, active low; after reset the root row is written and then
// transactions are accepted. Clear takes the same root-row initialization.
module suffix_automaton_engine_unit import sae_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [4:0]  s_symbol,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [12:0] m_match_len,
    output logic [12:0] m_best_len,
    output logic [12:0] m_occurrences,
    output logic [1:0]  m_status
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    sae_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    sae_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .s_symbol      (s_symbol),
        .stat          (dp_stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_match_len   (m_match_len),
        .m_best_len    (m_best_len),
        .m_occurrences (m_occurrences),
        .m_status      (m_status)
    );

endmodule
